// ===== design/ugbs_pkg.sv =====
// Package for the UTF-8 glyph boundary splitter.
// Holds the decoder state and result types, status codes and the modifier test.
// No dependencies.
`default_nettype none

package ugbs_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CP_W     = 21;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PEND_W   = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NUL     = 2'd2;

  typedef struct packed {
    logic [PEND_W-1:0] pending_count;
    logic [CP_W-1:0]   partial_value;
    logic              glyph_open;
    logic              stopped;
  } ugbs_state_t;

  localparam ugbs_state_t STATE_CLEAR = '{
    pending_count: '0,
    partial_value: '0,
    glyph_open:    1'b0,
    stopped:       1'b0
  };

  typedef struct packed {
    logic [CP_W-1:0]     code_point;
    logic                glyph_start;
    logic [STATUS_W-1:0] status;
  } ugbs_result_t;

  // A code point in one of these ranges extends the glyph that is open.
  function automatic logic is_modifier(input logic [CP_W-1:0] c);
    return c inside {[21'h002B0 : 21'h0036F], [21'h0180B : 21'h0180F],
                     [21'h0200C : 21'h0200D], [21'h0FE00 : 21'h0FE0F],
                     [21'h1F3FB : 21'h1F3FF], [21'hE0100 : 21'hE01EF]};
  endfunction

endpackage

`default_nettype wire

// ===== design/ugbs_in_if.sv =====
// Input channel of the splitter: one byte of a string per request.
// Depends on ugbs_pkg for field widths.
`default_nettype none

interface ugbs_in_if;
  import ugbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              string_first;
  logic              string_last;

  modport source (output valid, output byte_in, output string_first,
                  output string_last, input ready);
  modport sink   (input valid, input byte_in, input string_first,
                  input string_last, output ready);
endinterface

`default_nettype wire

// ===== design/ugbs_out_if.sv =====
// Output channel of the splitter: one code point or status per request.
// Depends on ugbs_pkg for field widths.
`default_nettype none

interface ugbs_out_if;
  import ugbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CP_W-1:0]     code_point;
  logic                glyph_start;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output code_point, output glyph_start,
                  output status, input ready);
  modport sink   (input valid, input code_point, input glyph_start,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== design/ugbs_decode.sv =====
// Combinational UTF-8 decode step: one byte against the current state.
// Gives the next state and at most one result. Depends on ugbs_pkg.
`default_nettype none

module ugbs_decode
  import ugbs_pkg::*;
(
  input  ugbs_state_t       state,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              string_first,
  input  logic              string_last,
  output ugbs_state_t       state_next,
  output logic              emit,
  output ugbs_result_t      result
);

  ugbs_state_t     st;
  logic            code_ready;
  logic [CP_W-1:0] code;
  logic [CP_W-1:0] gathered;
  logic            bad;

  always_comb begin
    st         = string_first ? STATE_CLEAR : state;
    state_next = st;
    code_ready = 1'b0;
    code       = '0;
    bad        = 1'b0;
    gathered   = {st.partial_value[CP_W-7:0], byte_in[5:0]};
    emit       = 1'b0;
    result     = '{code_point: '0, glyph_start: 1'b0, status: STATUS_OK};

    if (!st.stopped) begin
      if (st.pending_count == '0) begin
        if (byte_in[7] == 1'b0) begin
          code_ready = 1'b1;
          code       = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        end else if (byte_in[7:6] == 2'b10) begin
          bad = 1'b1;
        end else if (byte_in[7:5] == 3'b110) begin
          state_next.pending_count = 2'd1;
          state_next.partial_value = {{(CP_W-5){1'b0}}, byte_in[4:0]};
        end else if (byte_in[7:4] == 4'b1110) begin
          state_next.pending_count = 2'd2;
          state_next.partial_value = {{(CP_W-4){1'b0}}, byte_in[3:0]};
        end else if (byte_in[7:3] == 5'b11110) begin
          state_next.pending_count = 2'd3;
          state_next.partial_value = {{(CP_W-3){1'b0}}, byte_in[2:0]};
        end else begin
          bad = 1'b1;
        end
      end else if (byte_in[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        state_next.pending_count = st.pending_count - 2'd1;
        state_next.partial_value = gathered;
        if (st.pending_count == 2'd1) begin
          state_next.partial_value = '0;
          code_ready               = 1'b1;
          code                     = gathered;
        end
      end

      // A NUL, however it was encoded, ends output just as bad input does.
      if (code_ready) begin
        emit = 1'b1;
        if (code == '0) begin
          result.status = STATUS_NUL;
          state_next.stopped       = 1'b1;
          state_next.pending_count = '0;
          state_next.partial_value = '0;
        end else begin
          result.code_point  = code;
          result.glyph_start = !(st.glyph_open && is_modifier(code));
          state_next.glyph_open = 1'b1;
        end
      end else if (bad || (string_last && state_next.pending_count != '0)) begin
        emit          = 1'b1;
        result.status = STATUS_INVALID;
        state_next.stopped       = 1'b1;
        state_next.pending_count = '0;
        state_next.partial_value = '0;
      end
    end

    if (string_last) begin
      state_next = STATE_CLEAR;
    end
  end

endmodule

`default_nettype wire

// ===== design/utf8_glyph_boundary_splitter_core.sv =====
// Top level of the UTF-8 glyph boundary splitter.
// Depends on ugbs_pkg, ugbs_in_if, ugbs_out_if and ugbs_decode.
//
//   channel  dir  request carries
//   in_ch    in   byte_in, string_first, string_last
//   out_ch   out  code_point, glyph_start, status (zero or one per byte)
//
// A byte is taken into the input register, decoded combinationally against the
// decoder state, and any result lands in the output register; one byte per cycle
// is sustained while out_ch does not stall.
// Reset clears the decoder state and both valid flags.
// A byte leaves the input register only when the output register is free or
// being emptied, so a stall on out_ch holds in_ch after one byte.
`default_nettype none

module utf8_glyph_boundary_splitter_core
  import ugbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ugbs_in_if.sink    in_ch,
  ugbs_out_if.source out_ch
);

  logic              held_valid;
  logic [BYTE_W-1:0] held_byte;
  logic              held_first;
  logic              held_last;

  ugbs_state_t  state;
  ugbs_state_t  state_next;
  logic         emit;
  ugbs_result_t result;
  ugbs_result_t out_reg;
  logic         out_valid;
  logic         advance;

  assign advance     = held_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !held_valid || advance;

  ugbs_decode u_decode (
    .state        (state),
    .byte_in      (held_byte),
    .string_first (held_first),
    .string_last  (held_last),
    .state_next   (state_next),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ch.ready) begin
      held_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      held_byte  <= in_ch.byte_in;
      held_first <= in_ch.string_first;
      held_last  <= in_ch.string_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_reg <= result;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.code_point  = out_reg.code_point;
  assign out_ch.glyph_start = out_reg.glyph_start;
  assign out_ch.status      = out_reg.status;

endmodule

`default_nettype wire

// ===== sim/ugbs_tb_pkg.sv =====
// Scoreboard for the UTF-8 glyph boundary splitter testbench.
// Predicts code points and status results from accepted bytes; depends on ugbs_pkg.
`timescale 1ns / 100ps

package ugbs_tb_pkg;
  import ugbs_pkg::*;

  class glyph_scoreboard;
    ugbs_result_t      expected_results[$];
    int unsigned       errors;
    logic [PEND_W-1:0] seq_left;
    logic [CP_W-1:0]   cp_acc;
    logic              glyph_open;
    logic              halted;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      seq_left   = '0;
      cp_acc     = '0;
      glyph_open = 1'b0;
      halted     = 1'b0;
    endfunction

    function bit extends_glyph(input logic [CP_W-1:0] c);
      return (c >= 21'h002B0 && c <= 21'h0036F) || (c >= 21'h0180B && c <= 21'h0180F) ||
             (c == 21'h0200C || c == 21'h0200D) || (c >= 21'h0FE00 && c <= 21'h0FE0F) ||
             (c >= 21'h1F3FB && c <= 21'h1F3FF) || (c >= 21'hE0100 && c <= 21'hE01EF);
    endfunction

    // A status result halts output until the next string begins.
    function ugbs_result_t stop_with(input logic [STATUS_W-1:0] st);
      ugbs_result_t r;
      r.code_point  = '0;
      r.glyph_start = 1'b0;
      r.status      = st;
      halted   = 1'b1;
      seq_left = '0;
      cp_acc   = '0;
      return r;
    endfunction

    function ugbs_result_t finish_code_point(input logic [CP_W-1:0] c);
      ugbs_result_t r;
      if (c == '0) begin
        return stop_with(STATUS_NUL);
      end
      r.code_point  = c;
      r.glyph_start = !(glyph_open && extends_glyph(c));
      r.status      = STATUS_OK;
      glyph_open    = 1'b1;
      return r;
    endfunction

    function void note_byte(input logic [BYTE_W-1:0] b, input logic first, input logic last);
      ugbs_result_t r;
      bit           emitted;
      emitted = 1'b0;
      if (first) begin
        clear_state();
      end
      if (!halted) begin
        if (seq_left == 0) begin
          if (!b[7]) begin
            r = finish_code_point(CP_W'(b));
            emitted = 1'b1;
          end else if (b[7:6] == 2'b10) begin
            r = stop_with(STATUS_INVALID);
            emitted = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            seq_left = 2'd1;
            cp_acc   = CP_W'(b[4:0]);
          end else if (b[7:4] == 4'b1110) begin
            seq_left = 2'd2;
            cp_acc   = CP_W'(b[3:0]);
          end else if (b[7:3] == 5'b11110) begin
            seq_left = 2'd3;
            cp_acc   = CP_W'(b[2:0]);
          end else begin
            r = stop_with(STATUS_INVALID);
            emitted = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          r = stop_with(STATUS_INVALID);
          emitted = 1'b1;
        end else begin
          cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
          seq_left = seq_left - 2'd1;
          if (seq_left == 0) begin
            r = finish_code_point(cp_acc);
            cp_acc = '0;
            emitted = 1'b1;
          end
        end
        // A sequence still open at the end of the string counts as truncated.
        if (!emitted && last && seq_left != 0) begin
          r = stop_with(STATUS_INVALID);
          emitted = 1'b1;
        end
      end
      if (last) begin
        clear_state();
      end
      if (emitted) begin
        expected_results = {expected_results, r};
      end
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    function void check_result(input logic [CP_W-1:0] cp, input logic gs,
                               input logic [STATUS_W-1:0] st);
      ugbs_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: code_point %h glyph_start %b status %0d",
                 $time, cp, gs, st);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (cp !== want.code_point) begin
        $display("%0t: code_point mismatch: expected %h actual %h", $time, want.code_point, cp);
        errors++;
      end
      if (gs !== want.glyph_start) begin
        $display("%0t: glyph_start mismatch: expected %b actual %b", $time, want.glyph_start, gs);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
// Top-level testbench for utf8_glyph_boundary_splitter_core.
// Drives strings of well-formed, broken and random bytes with random idling and
// checks every result against glyph_scoreboard; depends on ugbs_pkg, the interfaces
// and ugbs_tb_pkg.
`timescale 1ns / 100ps

module tb_top;
  import ugbs_pkg::*;
  import ugbs_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ugbs_in_if  in_ch();
  ugbs_out_if out_ch();

  utf8_glyph_boundary_splitter_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  glyph_scoreboard sb = new();

  int src_idle_pct  = 17;
  int sink_idle_pct = 57;
  bit hold_req      = 1'b0;
  int bytes_sent    = 0;
  int idle_cycles   = 0;

  always #2 clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off whenever asked.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.code_point, out_ch.glyph_start, out_ch.status);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic first, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.byte_in      <= b;
    in_ch.string_first <= first;
    in_ch.string_last  <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(b, first, last);
    bytes_sent++;
  endtask

  task automatic send_string(input logic [BYTE_W-1:0] s[$], input bit mark_first,
                             input bit mark_last);
    foreach (s[i]) begin
      push_byte(s[i], mark_first && i == 0, mark_last && i == s.size() - 1);
    end
  endtask

  // Holds the input idle until every predicted result has been collected.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic void append_utf8(ref logic [BYTE_W-1:0] q[$], input logic [CP_W-1:0] cp);
    if (cp == '0 && $urandom_range(0, 1)) begin
      // Overlong two-byte form of NUL.
      q = {q, 8'hC0, 8'h80};
    end else if (cp < 21'h80) begin
      q = {q, cp[7:0]};
    end else if (cp < 21'h800) begin
      q = {q, {3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      q = {q, {4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    end else begin
      q = {q, {5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
           {2'b10, cp[5:0]}};
    end
  endfunction

  function automatic logic [CP_W-1:0] pick_code_point();
    int unsigned     sel;
    int unsigned     off;
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    sel = $urandom_range(0, 31);
    if (sel < 10) begin
      return CP_W'($urandom_range(1, 'h7F));
    end else if (sel < 13) begin
      return CP_W'($urandom_range('h80, 'h7FF));
    end else if (sel < 16) begin
      return CP_W'($urandom_range('h800, 'hFFFF));
    end else if (sel < 19) begin
      return CP_W'($urandom_range('h10000, 'h1FFFFF));
    end else if (sel < 30) begin
      // Modifier ranges, with their immediate neighbours now and then.
      case ($urandom_range(0, 5))
        0:       begin lo = 21'h002B0; hi = 21'h0036F; end
        1:       begin lo = 21'h0180B; hi = 21'h0180F; end
        2:       begin lo = 21'h0200C; hi = 21'h0200D; end
        3:       begin lo = 21'h0FE00; hi = 21'h0FE0F; end
        4:       begin lo = 21'h1F3FB; hi = 21'h1F3FF; end
        default: begin lo = 21'hE0100; hi = 21'hE01EF; end
      endcase
      off = $urandom_range(0, 7);
      if (off == 0) begin
        return lo - 21'd1;
      end else if (off == 1) begin
        return hi + 21'd1;
      end
      return CP_W'($urandom_range(lo, hi));
    end else if (sel == 30) begin
      case ($urandom_range(0, 6))
        0:       return 21'h7F;
        1:       return 21'h80;
        2:       return 21'h7FF;
        3:       return 21'h800;
        4:       return 21'hFFFF;
        5:       return 21'h10000;
        default: return 21'h1FFFFF;
      endcase
    end
    return '0;
  endfunction

  task automatic run_random(input int count);
    logic [BYTE_W-1:0] bytes_q[$];
    int                stop_at;
    int                kind;
    int                idx;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      bytes_q.delete();
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        repeat ($urandom_range(1, 6)) append_utf8(bytes_q, pick_code_point());
      end
      if (kind < 7) begin
        send_string(bytes_q, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      end else if (kind == 7) begin
        // Broken string: cut short or with one byte replaced.
        if ($urandom_range(0, 1) && bytes_q.size() > 1) begin
          void'(bytes_q.pop_back());
        end else begin
          idx = $urandom_range(0, bytes_q.size() - 1);
          bytes_q[idx] = BYTE_W'($urandom_range(0, 255));
        end
        send_string(bytes_q, 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input int count);
    drain();
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    run_random(count / 2);
    hold_req <= 1'b1;
    run_random(count - count / 2);
  endtask

  initial begin
    logic [BYTE_W-1:0] dir_bytes[$];
    in_ch.valid        = 1'b0;
    in_ch.byte_in      = '0;
    in_ch.string_first = 1'b0;
    in_ch.string_last  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Largest one-byte value, a modifier extending it, then the largest code point.
    dir_bytes = '{8'h7F, 8'hCC, 8'hAF, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string(dir_bytes, 1'b1, 1'b1);
    // Overlong NUL stops the string, so the byte after it is dropped.
    dir_bytes = '{8'hC0, 8'h80, 8'h41};
    send_string(dir_bytes, 1'b1, 1'b1);
    dir_bytes = '{8'h80};
    send_string(dir_bytes, 1'b1, 1'b1);
    dir_bytes = '{8'hFF};
    send_string(dir_bytes, 1'b1, 1'b1);
    dir_bytes = '{8'hE2, 8'h41};
    send_string(dir_bytes, 1'b1, 1'b1);
    dir_bytes = '{8'hE2, 8'h80};
    send_string(dir_bytes, 1'b1, 1'b1);
    dir_bytes = '{8'h00};
    send_string(dir_bytes, 1'b1, 1'b1);
    // A modifier opening a string begins a glyph; no first mark is needed after a last.
    dir_bytes = '{8'hE2, 8'h80, 8'h8C};
    send_string(dir_bytes, 1'b0, 1'b1);

    run_phase(17, 57, 430);
    run_phase(57, 17, 430);
    run_phase(0, 0, 440);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (sb.outstanding() != 0) begin
        $display("%0t: %0d expected results never arrived", $time, sb.outstanding());
      end
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
